// ----- hw/rtl/mpmc_pkg.sv -----
// Shared types, operation/status codes and sequencer step codes for the pattern counter.
`default_nettype none
package mpmc_pkg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_byte;
        logic       last;
        logic [9:0] pattern_index;
    } mpmc_in_t;

    typedef struct packed {
        logic [9:0]  pattern_id;
        logic [31:0] match_count;
        logic [1:0]  status;
    } mpmc_out_t;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_BUILD    = 3'd1;
    localparam logic [2:0] OP_SCAN     = 3'd2;
    localparam logic [2:0] OP_FINALIZE = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NODE_FULL = 2'd1;
    localparam logic [1:0] STS_PAT_FULL  = 2'd2;
    localparam logic [1:0] STS_BAD_INDEX = 2'd3;

    // sequencer steps, shared by controller (state) and datapath (command decode)
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CLR    = 5'd1;
    localparam logic [4:0] ST_INS_A  = 5'd2;
    localparam logic [4:0] ST_INS_B  = 5'd3;
    localparam logic [4:0] ST_SCN_A  = 5'd4;
    localparam logic [4:0] ST_SCN_B  = 5'd5;
    localparam logic [4:0] ST_SCN_C  = 5'd6;
    localparam logic [4:0] ST_QRY_A  = 5'd7;
    localparam logic [4:0] ST_QRY_B  = 5'd8;
    localparam logic [4:0] ST_QRY_C  = 5'd9;
    localparam logic [4:0] ST_BLD_G1 = 5'd10;
    localparam logic [4:0] ST_BLD_G2 = 5'd11;
    localparam logic [4:0] ST_BLD_G3 = 5'd12;
    localparam logic [4:0] ST_BLD_N1 = 5'd13;
    localparam logic [4:0] ST_BLD_N2 = 5'd14;
    localparam logic [4:0] ST_BLD_N3 = 5'd15;
    localparam logic [4:0] ST_FIN_1  = 5'd16;
    localparam logic [4:0] ST_FIN_2  = 5'd17;
    localparam logic [4:0] ST_FIN_3  = 5'd18;
    localparam logic [4:0] ST_FIN_4  = 5'd19;
    localparam logic [4:0] ST_DONE   = 5'd20;

    typedef struct packed {
        logic [4:0] step;
        logic       accept;
        logic       push;
    } mpmc_cmd_t;

    typedef struct packed {
        logic built;
        logic alloc;
        logic row_end;
        logic bfs_done;
        logic fin_empty;
        logic fin_last;
        logic q_bad;
    } mpmc_sts_t;

    function automatic logic [7:0] mpmc_sym_of(input logic [7:0] b);
        logic [7:0] s;
        s = 8'd0;
        if (b >= 8'h61 && b <= 8'h7a) s = b - 8'h61;
        else if (b >= 8'h41 && b <= 8'h5a) s = b - 8'h41 + 8'd26;
        else if (b >= 8'h30 && b <= 8'h39) s = b - 8'h30 + 8'd52;
        else if (b == 8'h2d) s = 8'd62;
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mpmc_ctrl.sv -----
// Sequencer state machine for the pattern counter.
`default_nettype none
module mpmc_ctrl
    import mpmc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic [2:0] operation,
    output logic            item_stall,
    output logic            result_valid,
    input  wire logic       result_stall,
    input  wire mpmc_sts_t  sts,
    output mpmc_cmd_t       cmd
);

    logic [4:0] state_reg, state_next;
    logic       boot_reg, boot_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, push;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign push         = (state_reg == ST_DONE) && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign cmd          = '{step: state_reg, accept: accept, push: push};
    assign out_valid_next = push || (out_valid_reg && result_stall);

    always_comb
    begin
        state_next = state_reg;
        boot_next  = boot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_INSERT:   state_next = sts.built ? ST_DONE : ST_INS_A;
                        OP_BUILD:    state_next = sts.built ? ST_DONE : ST_BLD_G1;
                        OP_SCAN:     state_next = ST_SCN_A;
                        OP_FINALIZE: state_next = sts.fin_empty ? ST_DONE : ST_FIN_1;
                        OP_QUERY:    state_next = ST_QRY_A;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLR:
            begin
                if (sts.row_end)
                begin
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                    boot_next  = 1'b0;
                end
            end
            ST_INS_A:  state_next = ST_INS_B;
            ST_INS_B:  state_next = sts.alloc ? ST_CLR : ST_DONE;
            ST_SCN_A:  state_next = ST_SCN_B;
            ST_SCN_B:  state_next = ST_SCN_C;
            ST_SCN_C:  state_next = ST_DONE;
            ST_QRY_A:  state_next = sts.q_bad ? ST_DONE : ST_QRY_B;
            ST_QRY_B:  state_next = ST_QRY_C;
            ST_QRY_C:  state_next = ST_DONE;
            ST_BLD_G1: state_next = ST_BLD_G2;
            ST_BLD_G2: state_next = ST_BLD_G3;
            ST_BLD_G3: state_next = sts.row_end ? ST_BLD_N1 : ST_BLD_G1;
            ST_BLD_N1: state_next = sts.bfs_done ? ST_DONE : ST_BLD_N2;
            ST_BLD_N2: state_next = ST_BLD_N3;
            ST_BLD_N3: state_next = ST_BLD_G1;
            ST_FIN_1:  state_next = ST_FIN_2;
            ST_FIN_2:  state_next = ST_FIN_3;
            ST_FIN_3:  state_next = ST_FIN_4;
            ST_FIN_4:  state_next = sts.fin_last ? ST_DONE : ST_FIN_1;
            ST_DONE:   if (push) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;   // root row clear after reset
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/mpmc_dp.sv -----
// Datapath: trie, failure link, count, order and pattern memories plus walk registers.
`default_nettype none
module mpmc_dp
    import mpmc_pkg::*;
#(
    parameter int MAX_NODES     = 4096,
    parameter int ALPHABET_SIZE = 63,
    parameter int MAX_PATTERNS  = 1024,
    parameter int COUNT_WIDTH   = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire mpmc_cmd_t cmd,
    input  wire mpmc_in_t  item,
    output mpmc_sts_t      sts,
    output mpmc_out_t      result
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NCNT_W = NODE_W + 1;
    localparam int SYM_W  = $clog2(ALPHABET_SIZE);
    localparam int GA_W   = NODE_W + SYM_W;
    localparam int GDEPTH = MAX_NODES << SYM_W;
    localparam int PAT_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PCNT_W = $clog2(MAX_PATTERNS + 1);

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                       input logic [COUNT_WIDTH-1:0] b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
    endfunction

    // memories
    logic [NODE_W-1:0]      gmem [0:GDEPTH-1];
    logic [NODE_W-1:0]      fmem [0:MAX_NODES-1];
    logic [COUNT_WIDTH-1:0] cmem [0:MAX_NODES-1];
    logic [NODE_W-1:0]      bmem [0:MAX_NODES-1];
    logic [NODE_W-1:0]      pmem [0:MAX_PATTERNS-1];

    logic [NODE_W-1:0]      g_rdata, f_rdata, b_rdata, p_rdata;
    logic [COUNT_WIDTH-1:0] c_rdata;

    logic [GA_W-1:0]        g_raddr, g_waddr;
    logic [NODE_W-1:0]      g_wdata;
    logic                   g_we;
    logic [NODE_W-1:0]      f_raddr, f_waddr, f_wdata;
    logic                   f_we;
    logic [NODE_W-1:0]      c_raddr, c_waddr;
    logic [COUNT_WIDTH-1:0] c_wdata;
    logic                   c_we;
    logic [NODE_W-1:0]      b_raddr, b_waddr;
    logic                   b_we;
    logic [PAT_W-1:0]       p_raddr, p_waddr;
    logic                   p_we;

    // control state
    logic [NCNT_W-1:0] nodes_used_reg, nodes_used_next;
    logic [PCNT_W-1:0] patterns_used_reg, patterns_used_next;
    logic [NODE_W-1:0] ins_node_reg, ins_node_next;
    logic [NODE_W-1:0] scan_node_reg, scan_node_next;
    logic              built_reg, built_next;
    logic              fault_reg, fault_next;
    logic [SYM_W-1:0]  s_reg, s_next;
    logic [NODE_W-1:0] row_node_reg, row_node_next;
    logic [NCNT_W-1:0] head_reg, head_next;
    logic [NCNT_W-1:0] tail_reg, tail_next;
    logic [NCNT_W-1:0] k_reg, k_next;

    // payload
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic                   last_reg, last_next;
    logic [9:0]             qidx_reg, qidx_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [NODE_W-1:0]      fnode_reg, fnode_next;
    logic [NODE_W-1:0]      c_reg, c_next;
    logic [NODE_W-1:0]      n_reg, n_next;
    logic [NODE_W-1:0]      f_reg, f_next;
    logic [COUNT_WIDTH-1:0] cv_reg, cv_next;
    logic [9:0]             res_pid_reg, res_pid_next;
    logic [31:0]            res_count_reg, res_count_next;
    logic [1:0]             res_status_reg, res_status_next;
    mpmc_out_t              out_reg;

    logic [7:0]        sym8;
    logic [SYM_W-1:0]  sym_in;
    logic              room, pat_room, alloc, node_full, fault_now;
    logic [NODE_W-1:0] child_eff, ins_after;
    logic [63:0]       count_wide;

    assign sym8   = mpmc_sym_of(item.char_byte);
    assign sym_in = ({1'b0, sym8} < 9'(ALPHABET_SIZE)) ? SYM_W'(sym8) : '0;

    assign room      = nodes_used_reg < NCNT_W'(MAX_NODES);
    assign pat_room  = patterns_used_reg < PCNT_W'(MAX_PATTERNS);
    assign alloc     = (g_rdata == '0) && room;
    assign node_full = (g_rdata == '0) && !room;
    assign fault_now = fault_reg || node_full;
    assign child_eff = (g_rdata != '0) ? g_rdata :
                       (alloc ? nodes_used_reg[NODE_W-1:0] : '0);
    assign ins_after = (child_eff != '0) ? child_eff : ins_node_reg;
    assign count_wide = 64'(c_rdata);

    assign sts.built     = built_reg;
    assign sts.alloc     = alloc;
    assign sts.row_end   = (s_reg == SYM_W'(ALPHABET_SIZE - 1));
    assign sts.bfs_done  = (head_reg >= tail_reg);
    assign sts.fin_empty = !built_reg || (nodes_used_reg == NCNT_W'(1));
    assign sts.fin_last  = (k_reg == '0);
    assign sts.q_bad     = (32'(qidx_reg) >= 32'(patterns_used_reg)) ||
                           (32'(qidx_reg) >= MAX_PATTERNS);

    assign result = out_reg;

    always_comb
    begin
        nodes_used_next    = nodes_used_reg;
        patterns_used_next = patterns_used_reg;
        ins_node_next      = ins_node_reg;
        scan_node_next     = scan_node_reg;
        built_next         = built_reg;
        fault_next         = fault_reg;
        s_next             = s_reg;
        row_node_next      = row_node_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        k_next             = k_reg;
        sym_next           = sym_reg;
        last_next          = last_reg;
        qidx_next          = qidx_reg;
        node_next          = node_reg;
        fnode_next         = fnode_reg;
        c_next             = c_reg;
        n_next             = n_reg;
        f_next             = f_reg;
        cv_next            = cv_reg;
        res_pid_next       = res_pid_reg;
        res_count_next     = res_count_reg;
        res_status_next    = res_status_reg;

        g_raddr = {node_reg, s_reg};
        g_we    = 1'b0;
        g_waddr = {ins_node_reg, sym_reg};
        g_wdata = '0;
        f_raddr = b_rdata;
        f_we    = 1'b0;
        f_waddr = row_node_reg;
        f_wdata = '0;
        c_raddr = b_rdata;
        c_we    = 1'b0;
        c_waddr = row_node_reg;
        c_wdata = '0;
        b_raddr = head_reg[NODE_W-1:0];
        b_we    = 1'b0;
        b_waddr = tail_reg[NODE_W-1:0];
        p_raddr = PAT_W'(qidx_reg);
        p_we    = 1'b0;
        p_waddr = PAT_W'(patterns_used_reg);

        unique case (cmd.step)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    sym_next        = sym_in;
                    last_next       = item.last;
                    qidx_next       = item.pattern_index;
                    res_pid_next    = '0;
                    res_count_next  = '0;
                    res_status_next = STS_OK;
                    if (item.operation == OP_BUILD && !built_reg)
                    begin
                        built_next = 1'b1;
                        node_next  = '0;
                        fnode_next = '0;
                        s_next     = '0;
                        head_next  = '0;
                        tail_next  = '0;
                    end
                    if (item.operation == OP_FINALIZE)
                        k_next = nodes_used_reg - NCNT_W'(1);
                end
            end
            ST_CLR:
            begin
                g_we    = 1'b1;
                g_waddr = {row_node_reg, s_reg};
                f_we    = 1'b1;
                c_we    = 1'b1;
                s_next  = sts.row_end ? '0 : s_reg + SYM_W'(1);
            end
            ST_INS_A: g_raddr = {ins_node_reg, sym_reg};
            ST_INS_B:
            begin
                if (alloc)
                begin
                    g_we            = 1'b1;
                    g_wdata         = nodes_used_reg[NODE_W-1:0];
                    nodes_used_next = nodes_used_reg + NCNT_W'(1);
                    row_node_next   = nodes_used_reg[NODE_W-1:0];
                    s_next          = '0;
                end
                if (node_full)
                    res_status_next = STS_NODE_FULL;
                if (last_reg)
                begin
                    if (fault_now)
                        res_status_next = STS_NODE_FULL;
                    else if (!pat_room)
                        res_status_next = STS_PAT_FULL;
                    else
                    begin
                        p_we               = 1'b1;
                        res_pid_next       = 10'(patterns_used_reg);
                        patterns_used_next = patterns_used_reg + PCNT_W'(1);
                    end
                    fault_next    = 1'b0;
                    ins_node_next = '0;
                end
                else
                begin
                    fault_next    = fault_now;
                    ins_node_next = ins_after;
                end
            end
            ST_SCN_A: g_raddr = {scan_node_reg, sym_reg};
            ST_SCN_B:
            begin
                c_raddr = g_rdata;
                n_next  = g_rdata;
            end
            ST_SCN_C:
            begin
                c_we           = 1'b1;
                c_waddr        = n_reg;
                c_wdata        = sat_add(c_rdata, COUNT_WIDTH'(1));
                scan_node_next = last_reg ? '0 : n_reg;
            end
            ST_QRY_A: if (sts.q_bad) res_status_next = STS_BAD_INDEX;
            ST_QRY_B: c_raddr = p_rdata;
            ST_QRY_C:
                res_count_next = (count_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : count_wide[31:0];
            ST_BLD_G1: g_raddr = {node_reg, s_reg};
            ST_BLD_G2:
            begin
                g_raddr = {fnode_reg, s_reg};
                c_next  = g_rdata;
            end
            ST_BLD_G3:
            begin
                // g_rdata holds the failure target's transition on this symbol
                if (c_reg != '0)
                begin
                    f_we      = 1'b1;
                    f_waddr   = c_reg;
                    f_wdata   = (node_reg == '0) ? '0 : g_rdata;
                    b_we      = 1'b1;
                    tail_next = tail_reg + NCNT_W'(1);
                end
                else if (node_reg != '0)
                begin
                    g_we    = 1'b1;
                    g_waddr = {node_reg, s_reg};
                    g_wdata = g_rdata;
                end
                s_next = sts.row_end ? '0 : s_reg + SYM_W'(1);
            end
            ST_BLD_N1: if (!sts.bfs_done) head_next = head_reg + NCNT_W'(1);
            ST_BLD_N2: node_next = b_rdata;
            ST_BLD_N3: fnode_next = f_rdata;
            ST_FIN_1:
            begin
                b_raddr = NODE_W'(k_reg - NCNT_W'(1));
                k_next  = k_reg - NCNT_W'(1);
            end
            ST_FIN_2: ;
            ST_FIN_3:
            begin
                f_next  = f_rdata;
                cv_next = c_rdata;
                c_raddr = f_rdata;
            end
            ST_FIN_4:
            begin
                c_we    = 1'b1;
                c_waddr = f_reg;
                c_wdata = sat_add(c_rdata, cv_reg);
            end
            default: ;
        endcase
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (g_we) gmem[g_waddr] <= g_wdata;
        g_rdata <= gmem[g_raddr];
        if (f_we) fmem[f_waddr] <= f_wdata;
        f_rdata <= fmem[f_raddr];
        if (c_we) cmem[c_waddr] <= c_wdata;
        c_rdata <= cmem[c_raddr];
        if (b_we) bmem[b_waddr] <= c_reg;
        b_rdata <= bmem[b_raddr];
        if (p_we) pmem[p_waddr] <= ins_after;
        p_rdata <= pmem[p_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg    <= NCNT_W'(1);
            patterns_used_reg <= '0;
            ins_node_reg      <= '0;
            scan_node_reg     <= '0;
            built_reg         <= 1'b0;
            fault_reg         <= 1'b0;
            s_reg             <= '0;
            row_node_reg      <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            k_reg             <= '0;
        end
        else
        begin
            nodes_used_reg    <= nodes_used_next;
            patterns_used_reg <= patterns_used_next;
            ins_node_reg      <= ins_node_next;
            scan_node_reg     <= scan_node_next;
            built_reg         <= built_next;
            fault_reg         <= fault_next;
            s_reg             <= s_next;
            row_node_reg      <= row_node_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            k_reg             <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        qidx_reg       <= qidx_next;
        node_reg       <= node_next;
        fnode_reg      <= fnode_next;
        c_reg          <= c_next;
        n_reg          <= n_next;
        f_reg          <= f_next;
        cv_reg         <= cv_next;
        res_pid_reg    <= res_pid_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        if (cmd.push)
            out_reg <= '{pattern_id: res_pid_reg, match_count: res_count_reg,
                         status: res_status_reg};
    end

endmodule
`default_nettype wire

// ----- hw/rtl/multi_pattern_match_counter_unit.sv -----
// Top level of the multi-pattern occurrence counter (Aho-Corasick).
//
//   channel  | handshake                   | payload
//   item     | item_valid / item_stall     | item   (mpmc_in_t)
//   result   | result_valid / result_stall | result (mpmc_out_t)
//
// One transaction in flight; each item gives exactly one result transaction.
// Insert clears the goto row of a newly allocated node one entry a cycle; query
// stops early on a bad index; build visits each node's goto row symbol by symbol;
// finalize walks the non-root nodes; repeated build, insert after build and unused
// codes go straight to the result. The next item is accepted once the result has been
// pushed. The goto, failure and count memories each have one registered read port.
// After reset the root row is cleared with item_stall high.
// A stalled result holds in the output register; the next result waits for it to leave.
`default_nettype none
module multi_pattern_match_counter_unit
    import mpmc_pkg::*;
#(
    parameter int MAX_NODES     = 4096,
    parameter int ALPHABET_SIZE = 63,
    parameter int MAX_PATTERNS  = 1024,
    parameter int COUNT_WIDTH   = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire mpmc_in_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output mpmc_out_t      result
);

    mpmc_cmd_t cmd;
    mpmc_sts_t sts;

    mpmc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .operation    (item.operation),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    mpmc_dp #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_PATTERNS  (MAX_PATTERNS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .sts    (sts),
        .result (result)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/mpmc_checker.sv -----
// Port-level checks for the pattern counter, bound to the top level.
`default_nettype none
module mpmc_checker
    import mpmc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      item_valid,
    input wire logic      item_stall,
    input wire mpmc_in_t  item,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire mpmc_out_t result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    // a stalled input transaction stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled input transaction changed");

    // failed transactions carry no id and no count
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STS_OK) |->
            (result.pattern_id == 10'd0) && (result.match_count == 32'd0))
        else $error("failed transaction with nonzero payload");

    // one transaction at a time: the block is busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken while busy");

endmodule

bind multi_pattern_match_counter_unit mpmc_checker u_mpmc_checker (.*);
`default_nettype wire
